>>> sv/wfvc_pkg.sv
`timescale 1ns / 1ps
// Package for the water fill valve controller: event codes, register
// layout and the structs passed between the controller modules. No dependencies.
package wfvc_pkg;

  localparam int unsigned KindW    = 3;
  localparam int unsigned PctW     = 7;
  localparam int unsigned DebW     = 16;
  localparam int unsigned AddrW    = 3;
  localparam int unsigned DataW    = 32;

  localparam logic [PctW-1:0] CutoffReset   = 7'd90;
  localparam logic [DebW-1:0] DebounceReset = 16'd100;

  // Register index taken from the word address.
  localparam logic RegCutoff   = 1'b0;
  localparam logic RegDebounce = 1'b1;

  typedef enum logic [KindW-1:0] {
    KIND_TICK       = 3'd0,
    KIND_BUTTON     = 3'd1,
    KIND_SENSOR_ON  = 3'd2,
    KIND_SENSOR_OFF = 3'd3,
    KIND_LEVEL_RDY  = 3'd4
  } kind_t;

  typedef struct packed {
    logic [PctW-1:0] cutoff_percent;
    logic [DebW-1:0] debounce_ticks;
  } cfg_t;

  typedef struct packed {
    logic valve_open;
    logic sensor_power;
    logic fill_busy;
  } result_t;

endpackage

>>> sv/wfvc_cfg.sv
`timescale 1ns / 1ps
// Configuration register file of the fill valve controller, APB-style port.
// Depends on wfvc_pkg.
module wfvc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wfvc_pkg::AddrW-1:0]    paddr,
  input  logic [wfvc_pkg::DataW-1:0]    pwdata,
  output logic [wfvc_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output wfvc_pkg::cfg_t                cfg
);
  import wfvc_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cutoff_percent <= CutoffReset;
      cfg.debounce_ticks <= DebounceReset;
    end else if (wr_en) begin
      unique case (paddr[2])
        RegCutoff:   cfg.cutoff_percent <= pwdata[PctW-1:0];
        RegDebounce: cfg.debounce_ticks <= pwdata[DebW-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      RegCutoff:   prdata[PctW-1:0] = cfg.cutoff_percent;
      RegDebounce: prdata[DebW-1:0] = cfg.debounce_ticks;
      default:     prdata = '0;
    endcase
  end

endmodule

>>> sv/wfvc_step.sv
`timescale 1ns / 1ps
// Fill state machine: holds phase, stop flag, last sensor edge and settle
// counter, and computes the result of one event. Depends on wfvc_pkg.
module wfvc_step (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [wfvc_pkg::KindW-1:0] kind,
  input  logic [wfvc_pkg::PctW-1:0]  water_percent,
  input  logic                       heater_on,
  input  wfvc_pkg::cfg_t             cfg,
  output wfvc_pkg::result_t          result
);
  import wfvc_pkg::*;

  typedef enum logic [2:0] {
    PH_INIT   = 3'd0,
    PH_IDLE   = 3'd1,
    PH_FILL   = 3'd2,
    PH_SETTLE = 3'd3
  } phase_t;

  typedef enum logic [1:0] {
    SL_UNKNOWN = 2'd0,
    SL_ON      = 2'd1,
    SL_OFF     = 2'd2
  } sensor_t;

  phase_t          phase, phase_next;
  sensor_t         sensor_last, sensor_last_next;
  logic            stop_flag, stop_flag_next;
  logic [DebW-1:0] settle_count, settle_count_next;
  logic            at_cutoff;
  logic            deb_zero;

  assign at_cutoff = water_percent >= cfg.cutoff_percent;
  assign deb_zero  = cfg.debounce_ticks == '0;

  always_comb begin
    phase_next        = phase;
    sensor_last_next  = sensor_last;
    stop_flag_next    = stop_flag;
    settle_count_next = settle_count;

    unique case (kind)
      KIND_TICK: begin
        if (phase == PH_SETTLE) begin
          if (settle_count != '0) begin
            settle_count_next = settle_count - 1'b1;
          end
          if (settle_count <= DebW'(1)) begin
            phase_next = PH_IDLE;
          end
        end
      end
      KIND_BUTTON, KIND_SENSOR_ON: begin
        if (kind == KIND_BUTTON && phase == PH_FILL) begin
          stop_flag_next = 1'b1;
        end else if (kind == KIND_BUTTON || sensor_last != SL_ON) begin
          if (kind == KIND_SENSOR_ON) begin
            sensor_last_next = SL_ON;
          end
          if (phase == PH_IDLE) begin
            stop_flag_next = 1'b0;
            if (!heater_on && !at_cutoff) begin
              phase_next = PH_FILL;
            end else if (deb_zero) begin
              // A refused start closes at once and settles like a finished fill.
              phase_next        = PH_IDLE;
              settle_count_next = '0;
            end else begin
              phase_next        = PH_SETTLE;
              settle_count_next = cfg.debounce_ticks;
            end
          end
        end
      end
      KIND_SENSOR_OFF: begin
        if (sensor_last != SL_OFF) begin
          sensor_last_next = SL_OFF;
          stop_flag_next   = 1'b1;
        end
      end
      KIND_LEVEL_RDY: begin
        if (phase == PH_INIT) begin
          phase_next = PH_IDLE;
        end
      end
      default: ;
    endcase

    // Every event, whatever its kind, ends with the stop check while filling.
    if (phase_next == PH_FILL && (stop_flag_next || at_cutoff)) begin
      if (deb_zero) begin
        phase_next        = PH_IDLE;
        settle_count_next = '0;
      end else begin
        phase_next        = PH_SETTLE;
        settle_count_next = cfg.debounce_ticks;
      end
    end

    result.valve_open   = phase_next == PH_FILL;
    result.sensor_power = phase_next == PH_IDLE || phase_next == PH_FILL;
    result.fill_busy    = phase_next == PH_FILL || phase_next == PH_SETTLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_INIT;
      sensor_last  <= SL_UNKNOWN;
      stop_flag    <= 1'b0;
      settle_count <= '0;
    end else if (en) begin
      phase        <= phase_next;
      sensor_last  <= sensor_last_next;
      stop_flag    <= stop_flag_next;
      settle_count <= settle_count_next;
    end
  end

endmodule

>>> sv/water_fill_valve_controller_core.sv
`timescale 1ns / 1ps
// Tank fill valve controller, top level. Depends on wfvc_pkg, wfvc_cfg and
// wfvc_step.
//
// Usage: each input beat on the item channel (item_valid/item_stall) is one
// event (kind, water_percent, heater_on). Every event yields exactly one
// result beat on the result channel (result_valid/result_stall) carrying
// valve_open, sensor_power and fill_busy as they stand after the event.
// The block has an input register and a result register with the state
// machine between them. An accepted beat waits in the input register until
// the state machine processes it; the result register then shows its
// result. One event is taken every cycle when the receiver keeps up.
// When the receiver stalls, the result register holds its beat; one more
// event may sit in the input register, after which item_stall rises until
// the result is taken.
// The APB-style port writes cutoff_percent (address 0) and debounce_ticks
// (address 4), unchecked: users write it only with no event in flight.
// A synchronous reset empties both registers, restores the register
// defaults (cutoff 90, debounce 100) and puts the controller in the
// waiting-for-level-sensor phase.
module water_fill_valve_controller_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wfvc_pkg::AddrW-1:0] paddr,
  input  logic [wfvc_pkg::DataW-1:0] pwdata,
  output logic [wfvc_pkg::DataW-1:0] prdata,
  output logic                       pready,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [wfvc_pkg::KindW-1:0] kind,
  input  logic [wfvc_pkg::PctW-1:0]  water_percent,
  input  logic                       heater_on,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic                       valve_open,
  output logic                       sensor_power,
  output logic                       fill_busy
);
  import wfvc_pkg::*;

  cfg_t            cfg;
  result_t         step_result;
  logic            in_full;
  logic [KindW-1:0] in_kind;
  logic [PctW-1:0] in_pct;
  logic            in_heat;
  logic            advance;
  logic            take_item;

  wfvc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The held event moves on when the result register is empty or being taken.
  assign advance    = in_full && (!result_valid || !result_stall);
  assign item_stall = in_full && !advance;
  assign take_item  = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take_item) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_item) begin
      in_kind <= kind;
      in_pct  <= water_percent;
      in_heat <= heater_on;
    end
  end

  wfvc_step u_step (
    .clk           (clk),
    .rst           (rst),
    .en            (advance),
    .kind          (in_kind),
    .water_percent (in_pct),
    .heater_on     (in_heat),
    .cfg           (cfg),
    .result        (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      valve_open   <= step_result.valve_open;
      sensor_power <= step_result.sensor_power;
      fill_busy    <= step_result.fill_busy;
    end
  end

endmodule
